/* sv/sps_pkg.sv */
package sps_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned TicksPerMsDef = 1;

  localparam int unsigned SnapWindow = 5;
  localparam int unsigned Precision  = 1024;
  localparam int unsigned ActiveMs   = 100;
  localparam int unsigned SweepMs    = 1000;
  localparam int unsigned LeadinMs   = 2500;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_ACT    = 2'd2,
    REQ_WRITE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_SWEEP    = 2'd1,
    MODE_ACTIVE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_DAMP  = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_UPPER = 2'd2,
    CFG_DEF   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLAMP,
    ST_RD,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_FIN,
    ST_TICK,
    ST_SWRD,
    ST_SWCMP,
    ST_DAMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       clamp;
    logic       rd_issue;
    logic       lk_next;
    logic       lk_exact;
    logic       lk_fallback;
    logic       div_start;
    logic       mul;
    logic       interp_fin;
    logic       activate;
    logic       tick;
    logic       sw_rd;
    logic       sw_eval;
    logic       damp;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    req_e  req;
    mode_e mode;
    logic  delay_zero;
    logic  lk_eq;
    logic  lk_lt;
    logic  lk_last;
    logic  div_done;
    logic  busy_out;
  } sts_t;

endpackage

/* sv/sps_if.sv */
interface sps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic signed [15:0] position;
  logic [3:0]  entry_index;
  logic signed [15:0] entry_domain;
  logic [15:0] entry_servo;
  modport source (output valid, req_type, position, entry_index, entry_domain,
                  entry_servo, input ready);
  modport sink (input valid, req_type, position, entry_index, entry_domain,
                entry_servo, output ready);
endinterface

interface sps_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_write;
  logic [15:0] pwm_position;
  logic [15:0] request_position;
  logic [15:0] actual_position;
  logic signed [15:0] domain_position;
  logic [1:0]  mode;
  modport source (output valid, pwm_write, pwm_position, request_position,
                  actual_position, domain_position, mode, input ready);
  modport sink (input valid, pwm_write, pwm_position, request_position,
                actual_position, domain_position, mode, output ready);
endinterface

interface sps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/servo_position_shaper_top.sv */
// channel   | dir | handshake       | payload
// in_if     | in  | valid / ready   | req_type, position, entry_index, entry_domain, entry_servo
// out_if    | out | valid / ready   | pwm_write, pwm_position, request_position, ...
// cfg_if    | in  | valid / ready   | index, data
// one item at a time, from the input transfer to a valid result: table write or tick
// while inactive passes decode and output, counting tick or damped step adds its tick or
// damp state, sweep step a table read and compare, set position or activate a clamp and a
// read and compare per table entry, plus the radix-2 divider, multiply and scale when two
// entries bracket the request; next item is taken once the result has been transferred out
// rst_ni clears mode, counters and positions; table contents stay undefined
module servo_position_shaper_top
  import sps_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned TicksPerMs = TicksPerMsDef
) (
  input logic clk_i,
  input logic rst_ni,
  sps_in_if.sink    in_if,
  sps_out_if.source out_if,
  sps_cfg_if.sink   cfg_if
);

  cmd_t cmd;
  sts_t sts;

  sps_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sps_dp #(
    .TableDepth (TableDepth),
    .TicksPerMs (TicksPerMs)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_if,
    .out_if,
    .cfg_if,
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

/* sv/sps_ctrl.sv */
module sps_ctrl
  import sps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i && !sts_i.busy_out) state_d = ST_DECODE;
      ST_DECODE: begin
        case (sts_i.req)
          REQ_SET, REQ_ACT: state_d = ST_CLAMP;
          REQ_WRITE:        state_d = ST_OUT;
          default: begin
            if (sts_i.mode == MODE_INACTIVE) state_d = ST_OUT;
            else if (!sts_i.delay_zero) state_d = ST_TICK;
            else if (sts_i.mode == MODE_SWEEP) state_d = ST_SWRD;
            else state_d = ST_DAMP;
          end
        endcase
      end
      ST_CLAMP:  state_d = ST_RD;
      ST_RD:     state_d = ST_CMP;
      ST_CMP: begin
        if (sts_i.lk_eq) state_d = ST_OUT;
        else if (sts_i.lk_lt) state_d = ST_DIV;
        else if (sts_i.lk_last) state_d = ST_OUT;
        else state_d = ST_RD;
      end
      ST_DIV:    if (sts_i.div_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_FIN;
      ST_FIN:    state_d = ST_OUT;
      ST_TICK:   state_d = ST_OUT;
      ST_SWRD:   state_d = ST_SWCMP;
      ST_SWCMP:  state_d = ST_OUT;
      ST_DAMP:   state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == ST_IDLE) && !sts_i.busy_out;
    case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i && !sts_i.busy_out;
      ST_DECODE: begin
        if (sts_i.req == REQ_ACT) cmd_o.activate = 1'b1;
        if (sts_i.req == REQ_TICK && sts_i.mode != MODE_INACTIVE
            && !sts_i.delay_zero) cmd_o.tick = 1'b1;
      end
      ST_CLAMP:  cmd_o.clamp = 1'b1;
      ST_RD:     cmd_o.rd_issue = 1'b1;
      ST_CMP: begin
        if (sts_i.lk_eq) cmd_o.lk_exact = 1'b1;
        else if (sts_i.lk_lt) cmd_o.div_start = 1'b1;
        else if (sts_i.lk_last) cmd_o.lk_fallback = 1'b1;
        else cmd_o.lk_next = 1'b1;
      end
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_FIN:    cmd_o.interp_fin = 1'b1;
      ST_SWRD:   cmd_o.sw_rd = 1'b1;
      ST_SWCMP:  cmd_o.sw_eval = 1'b1;
      ST_DAMP:   cmd_o.damp = 1'b1;
      ST_OUT:    cmd_o.out_load = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

/* sv/sps_div.sv */
module sps_div
  import sps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic [31:0] n_q, n_d, r_q, r_d, dv_q;
  logic        neg_q, zero_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic [31:0] rs;

  assign rs    = {r_q[30:0], n_q[31]};
  assign trial = {1'b0, rs} - {1'b0, dv_q};
  assign r_d   = trial[32] ? rs : trial[31:0];
  assign n_d   = {n_q[30:0], ~trial[32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= num_i[31] ? 32'(-num_i) : num_i;
      dv_q   <= den_i[31] ? 32'(-den_i) : den_i;
      r_q    <= '0;
      neg_q  <= num_i[31] ^ den_i[31];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o  = zero_q ? '0 : (neg_q ? 32'(-n_q) : n_q);

endmodule

/* sv/sps_dp.sv */
module sps_dp
  import sps_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned TicksPerMs = TicksPerMsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  sps_in_if.sink   in_if,
  sps_out_if.source out_if,
  sps_cfg_if.sink  cfg_if,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam logic [15:0] LeadinLd = 16'(LeadinMs * TicksPerMs - 1);
  localparam logic [15:0] SweepLd  = 16'(SweepMs * TicksPerMs - 1);
  localparam logic [15:0] ActiveLd = 16'(ActiveMs * TicksPerMs - 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  logic [7:0]         damp_q;
  logic signed [15:0] lower_q, upper_q, def_q;

  logic signed [15:0] tdom [TableDepth];
  logic [15:0]        tsrv [TableDepth];

  req_e               req_q;
  logic signed [15:0] pos_q, cl_q;
  logic [3:0]         ei_q;
  logic signed [15:0] ed_q;
  logic [15:0]        es_q;

  mode_e       mode_q;
  logic [15:0] delay_q;
  logic [IdxW-1:0] sw_q;
  logic        pend_q;
  logic [15:0] tgt_q, sm_q;
  logic signed [15:0] dom_q;

  logic [IdxW-1:0] li_q;
  logic signed [15:0] rd_d0_q, rd_d1_q;
  logic [15:0]        rd_s0_q, rd_s1_q;
  logic [31:0]        prod_q;
  logic               pw_q;
  logic [15:0]        pwp_q;
  logic               ovalid_q;

  logic               div_done;
  logic signed [31:0] quo;
  logic [IdxW-1:0]    li_n;

  // sweep step: on sw_rd the current entry is latched; on sw_eval decide
  logic            sw_adv_q;
  logic            sw_show;
  logic [IdxW-1:0] sw_tgt;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q  <= '0;
      lower_q <= 16'sh8000;
      upper_q <= 16'sh7fff;
      def_q   <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_e'(cfg_if.index))
        CFG_DAMP:  damp_q  <= cfg_if.data[7:0];
        CFG_LOWER: lower_q <= cfg_if.data;
        CFG_UPPER: upper_q <= cfg_if.data;
        CFG_DEF:   def_q   <= cfg_if.data;
        default:   damp_q  <= damp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(in_if.req_type);
      pos_q <= in_if.position;
      ei_q  <= in_if.entry_index;
      ed_q  <= in_if.entry_domain;
      es_q  <= in_if.entry_servo;
    end
  end

  // table stores, written once per table write transfer whose index lies within TableDepth
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && req_q == REQ_WRITE && 32'(ei_q) < TableDepth) begin
      tdom[IdxW'(ei_q)] <= ed_q;
      tsrv[IdxW'(ei_q)] <= es_q;
    end
  end

  assign li_n = (li_q == LastIdx) ? li_q : li_q + IdxW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      rd_d0_q <= tdom[li_q];
      rd_s0_q <= tsrv[li_q];
      rd_d1_q <= tdom[li_n];
      rd_s1_q <= tsrv[li_n];
    end else if (cmd_i.sw_rd) begin
      rd_d0_q <= tdom[sw_q];
      rd_s0_q <= tsrv[sw_q];
    end else if (cmd_i.clamp) begin
      rd_s0_q <= tsrv[0];
    end
  end

  logic [15:0] fb_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp) fb_q <= tsrv[0];
  end

  logic signed [15:0] src;
  assign src = (req_q == REQ_ACT) ? def_q : pos_q;

  sps_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.div_start),
    .num_i   (32'(signed'(32'(Precision))) * 32'(cl_q - rd_d0_q)),
    .den_i   (32'(rd_d1_q) - 32'(rd_d0_q)),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  logic [15:0] diff;
  logic [23:0] dmp;
  assign diff = (sm_q > tgt_q) ? sm_q - tgt_q : tgt_q - sm_q;
  assign dmp  = 24'(sm_q * damp_q) + 24'(tgt_q * (9'd256 - 9'(damp_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_INACTIVE;
      delay_q  <= '0;
      sw_q     <= '0;
      pend_q   <= 1'b0;
      tgt_q    <= '0;
      sm_q     <= '0;
      dom_q    <= '0;
      li_q     <= '0;
      cl_q     <= '0;
      prod_q   <= '0;
      pw_q     <= 1'b0;
      pwp_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      if (cmd_i.load) begin
        pw_q  <= 1'b0;
        pwp_q <= '0;
      end
      if (cmd_i.clamp) begin
        li_q <= '0;
        if (src < lower_q) cl_q <= lower_q;
        else if (src > upper_q) cl_q <= upper_q;
        else cl_q <= src;
      end
      if (cmd_i.lk_next) li_q <= li_q + IdxW'(1);
      if (cmd_i.lk_exact) begin
        tgt_q <= rd_s0_q;
        dom_q <= cl_q;
      end
      if (cmd_i.lk_fallback) begin
        tgt_q <= fb_q;
        dom_q <= cl_q;
      end
      if (cmd_i.div_start) dom_q <= cl_q;
      if (cmd_i.mul) prod_q <= quo * (32'(rd_s1_q) - 32'(rd_s0_q));
      if (cmd_i.interp_fin) tgt_q <= 16'((prod_q >> 10) + 32'(rd_s0_q));
      if (cmd_i.activate) begin
        delay_q <= LeadinLd;
        pend_q  <= 1'b1;
        mode_q  <= MODE_SWEEP;
      end
      if (cmd_i.tick) delay_q <= delay_q - 16'd1;
      if (cmd_i.sw_rd && pend_q) begin
        pend_q <= 1'b0;
        sw_q   <= '0;
      end
      if (cmd_i.sw_eval) begin
        if (!pend_q && (sw_q == LastIdx || rd_d0_q == upper_q) && !sw_adv_q) begin
          mode_q <= MODE_ACTIVE;
        end
      end
      if (cmd_i.damp) begin
        if (sm_q != tgt_q) begin
          sm_q  <= (diff < 16'(SnapWindow)) ? tgt_q : dmp[23:8];
          pw_q  <= 1'b1;
          pwp_q <= (diff < 16'(SnapWindow)) ? tgt_q : dmp[23:8];
        end
        delay_q <= ActiveLd;
      end
      if (cmd_i.out_load) ovalid_q <= 1'b1;
      if (sw_show) begin
        sm_q    <= tsrv[sw_tgt];
        pw_q    <= 1'b1;
        pwp_q   <= tsrv[sw_tgt];
        delay_q <= SweepLd;
        if (!sw_adv_q) sw_q <= sw_tgt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sw_adv_q <= 1'b0;
    else if (cmd_i.sw_rd) sw_adv_q <= pend_q;
  end
  assign sw_show = cmd_i.sw_eval &&
                   (sw_adv_q || !(sw_q == LastIdx || rd_d0_q == upper_q));
  assign sw_tgt  = sw_adv_q ? '0 : sw_q + IdxW'(1);

  assign sts_o.req        = req_q;
  assign sts_o.mode       = mode_q;
  assign sts_o.delay_zero = (delay_q == '0);
  assign sts_o.lk_eq      = (cl_q == rd_d0_q);
  assign sts_o.lk_lt      = (li_q != LastIdx) && (cl_q < rd_d1_q);
  assign sts_o.lk_last    = (li_q == LastIdx);
  assign sts_o.div_done   = div_done;
  assign sts_o.busy_out   = ovalid_q;

  assign out_if.valid            = ovalid_q;
  assign out_if.pwm_write        = pw_q;
  assign out_if.pwm_position     = pwp_q;
  assign out_if.request_position = tgt_q;
  assign out_if.actual_position  = sm_q;
  assign out_if.domain_position  = dom_q;
  assign out_if.mode             = mode_q;

endmodule

/* sv/sps_chk.sv */
module sps_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       pwm_write,
  input logic [15:0] pwm_position,
  input logic [15:0] actual_position,
  input logic [1:0] mode
);

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid) else $error("overlap");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("drop");
  a_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && pwm_write |-> pwm_position == actual_position) else $error("pwm");
  a_nopwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !pwm_write |-> pwm_position == 16'd0) else $error("pwm zero");
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && pwm_write |-> mode != 2'd0) else $error("mode");

endmodule

bind servo_position_shaper_top sps_chk u_chk (
  .clk_i,
  .rst_ni,
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .pwm_write       (out_if.pwm_write),
  .pwm_position    (out_if.pwm_position),
  .actual_position (out_if.actual_position),
  .mode            (out_if.mode)
);
